// File: sv/jacobi_eigen_symmetric_3x3_defines.svh
// ----------------------------------------------------------------------------
// Jacobi 3x3 eigen solver assertion macros
// Shared property wrappers; they compile to nothing under NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef JACOBI_EIGEN_SYMMETRIC_3X3_DEFINES_SVH
`define JACOBI_EIGEN_SYMMETRIC_3X3_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define JES3_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define JES3_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define JES3_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define JES3_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: sv/jes3_pkg.sv
// ----------------------------------------------------------------------------
// Jacobi 3x3 eigen solver package
// Widths, constants, CORDIC angle table and the rotation product program.
// ----------------------------------------------------------------------------
package jes3_pkg;

  localparam int MAT_W        = 64;
  localparam int V_W          = 40;
  localparam int Z_W          = 36;
  localparam int CS_W         = 33;
  localparam int GUARD        = 8;
  localparam int THR_W        = 31;
  localparam int ROT_W        = 6;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 31;
  localparam int OUT_W        = 32;
  localparam int CORDIC_STEPS = 31;
  localparam int NUM_OPS      = 25;
  localparam int NUM_DST      = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ROT   = 2'd1;

  localparam logic signed [Z_W-1:0]   PI_Q30      = 36'sd3373259426;
  localparam logic signed [MAT_W-1:0] GAIN_Q30    = 64'sd652032874;
  localparam logic signed [V_W-1:0]   ONE_V       = 40'sd1073741824;
  localparam logic [MAT_W-1:0]        NORM_COARSE = 64'd1 << 32;
  localparam logic [MAT_W-1:0]        NORM_LEVEL  = 64'd1 << 40;

  typedef enum logic [1:0] {PIV_01, PIV_02, PIV_12} piv_t;

  typedef enum logic [3:0] {
    A_C, A_S, A_APP, A_AQQ, A_APQ, A_ARP, A_ARQ,
    A_VP0, A_VP1, A_VP2, A_VQ0, A_VQ1, A_VQ2
  } asel_t;

  typedef enum logic [2:0] {B_C, B_S, B_CC, B_SS, B_CS} bsel_t;

  typedef enum logic [3:0] {
    D_CC, D_SS, D_CS, D_PP, D_QQ, D_RP, D_RQ,
    D_VP0, D_VP1, D_VP2, D_VQ0, D_VQ1, D_VQ2
  } dst_t;

  typedef enum logic [2:0] {ACC_SET, ACC_ADD, ACC_SUB, ACC_ADD2, ACC_SUB2} accop_t;

  typedef struct packed {
    asel_t  a;
    bsel_t  b;
    dst_t   d;
    accop_t op;
  } mop_t;

  function automatic logic [31:0] atan_q30(input logic [4:0] idx);
    logic [31:0] t;
    case (idx)
      5'd0:    t = 32'd843314857;
      5'd1:    t = 32'd497837829;
      5'd2:    t = 32'd263043837;
      5'd3:    t = 32'd133525159;
      5'd4:    t = 32'd67021687;
      5'd5:    t = 32'd33543516;
      5'd6:    t = 32'd16775851;
      5'd7:    t = 32'd8388437;
      5'd8:    t = 32'd4194283;
      5'd9:    t = 32'd2097149;
      default: t = 32'd1 << (5'd30 - idx);
    endcase
    return t;
  endfunction

  function automatic mop_t prog_op(input logic [4:0] pc);
    mop_t m;
    case (pc)
      5'd0:    m = '{A_C,   B_C,  D_CC,  ACC_SET};
      5'd1:    m = '{A_S,   B_S,  D_SS,  ACC_SET};
      5'd2:    m = '{A_C,   B_S,  D_CS,  ACC_SET};
      5'd3:    m = '{A_APP, B_CC, D_PP,  ACC_SET};
      5'd4:    m = '{A_APQ, B_CS, D_PP,  ACC_SUB2};
      5'd5:    m = '{A_AQQ, B_SS, D_PP,  ACC_ADD};
      5'd6:    m = '{A_APP, B_SS, D_QQ,  ACC_SET};
      5'd7:    m = '{A_APQ, B_CS, D_QQ,  ACC_ADD2};
      5'd8:    m = '{A_AQQ, B_CC, D_QQ,  ACC_ADD};
      5'd9:    m = '{A_ARP, B_C,  D_RP,  ACC_SET};
      5'd10:   m = '{A_ARQ, B_S,  D_RP,  ACC_SUB};
      5'd11:   m = '{A_ARP, B_S,  D_RQ,  ACC_SET};
      5'd12:   m = '{A_ARQ, B_C,  D_RQ,  ACC_ADD};
      5'd13:   m = '{A_VP0, B_C,  D_VP0, ACC_SET};
      5'd14:   m = '{A_VQ0, B_S,  D_VP0, ACC_SUB};
      5'd15:   m = '{A_VP0, B_S,  D_VQ0, ACC_SET};
      5'd16:   m = '{A_VQ0, B_C,  D_VQ0, ACC_ADD};
      5'd17:   m = '{A_VP1, B_C,  D_VP1, ACC_SET};
      5'd18:   m = '{A_VQ1, B_S,  D_VP1, ACC_SUB};
      5'd19:   m = '{A_VP1, B_S,  D_VQ1, ACC_SET};
      5'd20:   m = '{A_VQ1, B_C,  D_VQ1, ACC_ADD};
      5'd21:   m = '{A_VP2, B_C,  D_VP2, ACC_SET};
      5'd22:   m = '{A_VQ2, B_S,  D_VP2, ACC_SUB};
      5'd23:   m = '{A_VP2, B_S,  D_VQ2, ACC_SET};
      5'd24:   m = '{A_VQ2, B_C,  D_VQ2, ACC_ADD};
      default: m = '{A_C,   B_C,  D_CC,  ACC_SET};
    endcase
    return m;
  endfunction

endpackage

// File: sv/jacobi_eigen_symmetric_3x3.sv
// ----------------------------------------------------------------------------
// Jacobi 3x3 symmetric eigen solver
// Classical Jacobi rotations on a shared CORDIC unit and a shared multiplier.
// ----------------------------------------------------------------------------
// Channel   Handshake            Words
// in_       start / busy         one matrix (six entries)
// out_      out_strobe           three eigenpairs, largest first
// cfg_      cfg_we               threshold or rotation limit
//
// Each rotation runs 25 rounded products on the shared multiplier, two
// 31-step CORDIC passes, a normalize phase and the sequencer states. When
// pivot and diagonal difference are both zero the angle search is skipped.
// Busy stays high through the rotations and the emit states, and the three
// words leave on consecutive cycles. Reset sets the threshold to 1 and the
// limit to 50. The receiver cannot stall the result words.
// ----------------------------------------------------------------------------
`include "jacobi_eigen_symmetric_3x3_defines.svh"

module jacobi_eigen_symmetric_3x3 #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [DATA_WIDTH-1:0]        in_entry_xx,
  input  logic signed [DATA_WIDTH-1:0]        in_entry_xy,
  input  logic signed [DATA_WIDTH-1:0]        in_entry_xz,
  input  logic signed [DATA_WIDTH-1:0]        in_entry_yy,
  input  logic signed [DATA_WIDTH-1:0]        in_entry_yz,
  input  logic signed [DATA_WIDTH-1:0]        in_entry_zz,
  input  logic                                cfg_we,
  input  logic [jes3_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [jes3_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output logic                                out_strobe,
  output logic signed [DATA_WIDTH-1:0]        out_eigen_value,
  output logic signed [jes3_pkg::OUT_W-1:0]   out_vector_x,
  output logic signed [jes3_pkg::OUT_W-1:0]   out_vector_y,
  output logic signed [jes3_pkg::OUT_W-1:0]   out_vector_z,
  output logic [1:0]                          out_rank_index,
  output logic                                out_last
);
  import jes3_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_PIVOT  = 9'b000000010,
    S_LOAD   = 9'b000000100,
    S_VEC    = 9'b000001000,
    S_ROT    = 9'b000010000,
    S_MUL    = 9'b000100000,
    S_COMMIT = 9'b001000000,
    S_RANK   = 9'b010000000,
    S_EMIT   = 9'b100000000
  } st_t;

  localparam logic signed [MAT_W-1:0] EV_MAX = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
  localparam logic signed [MAT_W-1:0] EV_MIN = -EV_MAX - 64'sd1;
  localparam logic signed [MAT_W-1:0] EV_RND = 64'sd1 <<< (GUARD - 1);

  st_t                       state_r;
  piv_t                      k_r;
  logic [ROT_W-1:0]          it_r, maxrot_r;
  logic [THR_W-1:0]          thr_r;
  logic [4:0]                pc_r;
  logic                      issued_r;
  logic [1:0]                emit_r;

  logic signed [MAT_W-1:0]   diag_r [3];
  logic signed [MAT_W-1:0]   off_r  [3];
  logic signed [V_W-1:0]     vec_r  [3][3];
  logic signed [MAT_W-1:0]   app_r, aqq_r, apq_r, arp_r, arq_r;
  logic signed [V_W-1:0]     vp_r [3];
  logic signed [V_W-1:0]     vq_r [3];
  logic signed [CS_W-1:0]    c_r, s_r;
  logic signed [MAT_W-1:0]   acc_r [NUM_DST];
  logic signed [DATA_WIDTH-1:0] ev_r [3];

  logic                      strobe_r, last_r;
  logic signed [DATA_WIDTH-1:0] eig_r;
  logic signed [OUT_W-1:0]   vx_r, vy_r, vz_r;
  logic [1:0]                rank_r;

  // Pivot search
  logic signed [MAT_W-1:0]   mag [3];
  logic signed [MAT_W-1:0]   best, lim;
  piv_t                      kbest;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      mag[j] = off_r[j][MAT_W-1] ? -off_r[j] : off_r[j];
    end
    best  = mag[0];
    kbest = PIV_01;
    if (mag[1] > best) begin
      best  = mag[1];
      kbest = PIV_02;
    end
    if (mag[2] > best) begin
      best  = mag[2];
      kbest = PIV_12;
    end
    lim = $signed({{(MAT_W-THR_W-GUARD){1'b0}}, thr_r, {GUARD{1'b0}}});
  end

  // Shared CORDIC
  logic                      cv_start, cr_start, c_done;
  logic signed [Z_W-1:0]     c_z;
  logic signed [CS_W-1:0]    c_c, c_s;

  assign cv_start = (state_r == S_LOAD);
  assign cr_start = (state_r == S_VEC) && c_done;

  jes3_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .start_vec (cv_start),
    .start_rot (cr_start),
    .vx_in     (aqq_r - app_r),
    .vy_in     (apq_r <<< 1),
    .rz_in     (c_z >>> 1),
    .done      (c_done),
    .z_out     (c_z),
    .c_out     (c_c),
    .s_out     (c_s)
  );

  // Shared multiplier and product program
  mop_t                      mop;
  logic                      m_start, m_done;
  logic signed [MAT_W-1:0]   m_a, m_y, acc_cur, acc_nxt;
  logic signed [CS_W-1:0]    m_b;

  always_comb begin
    mop = prog_op(pc_r);
    case (mop.a)
      A_C:     m_a = MAT_W'(c_r);
      A_S:     m_a = MAT_W'(s_r);
      A_APP:   m_a = app_r;
      A_AQQ:   m_a = aqq_r;
      A_APQ:   m_a = apq_r;
      A_ARP:   m_a = arp_r;
      A_ARQ:   m_a = arq_r;
      A_VP0:   m_a = MAT_W'(vp_r[0]);
      A_VP1:   m_a = MAT_W'(vp_r[1]);
      A_VP2:   m_a = MAT_W'(vp_r[2]);
      A_VQ0:   m_a = MAT_W'(vq_r[0]);
      A_VQ1:   m_a = MAT_W'(vq_r[1]);
      A_VQ2:   m_a = MAT_W'(vq_r[2]);
      default: m_a = '0;
    endcase
    case (mop.b)
      B_C:     m_b = c_r;
      B_S:     m_b = s_r;
      B_CC:    m_b = acc_r[D_CC][CS_W-1:0];
      B_SS:    m_b = acc_r[D_SS][CS_W-1:0];
      B_CS:    m_b = acc_r[D_CS][CS_W-1:0];
      default: m_b = '0;
    endcase
    acc_cur = acc_r[mop.d];
    case (mop.op)
      ACC_SET:  acc_nxt = m_y;
      ACC_ADD:  acc_nxt = acc_cur + m_y;
      ACC_SUB:  acc_nxt = acc_cur - m_y;
      ACC_ADD2: acc_nxt = acc_cur + (m_y <<< 1);
      ACC_SUB2: acc_nxt = acc_cur - (m_y <<< 1);
      default:  acc_nxt = m_y;
    endcase
  end

  assign m_start = (state_r == S_MUL) && !issued_r;

  jes3_mulq u_mulq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (m_start),
    .a_in  (m_a),
    .b_in  (m_b),
    .done  (m_done),
    .y_out (m_y)
  );

  // Rotated values
  logic signed [MAT_W-1:0]   npp, nqq, nrp, nrq;
  logic signed [V_W-1:0]     nvp [3];
  logic signed [V_W-1:0]     nvq [3];

  always_comb begin
    npp    = acc_r[D_PP];
    nqq    = acc_r[D_QQ];
    nrp    = acc_r[D_RP];
    nrq    = acc_r[D_RQ];
    nvp[0] = acc_r[D_VP0][V_W-1:0];
    nvp[1] = acc_r[D_VP1][V_W-1:0];
    nvp[2] = acc_r[D_VP2][V_W-1:0];
    nvq[0] = acc_r[D_VQ0][V_W-1:0];
    nvq[1] = acc_r[D_VQ1][V_W-1:0];
    nvq[2] = acc_r[D_VQ2][V_W-1:0];
  end

  // Eigenvalue rounding and ranking
  logic signed [MAT_W-1:0]   ev_e [3];
  logic [1:0]                rank [3];
  logic [1:0]                sel;
  logic signed [V_W-1:0]     vsel [3];
  logic signed [V_W-1:0]     vclp [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ev_e[i] = (diag_r[i] + EV_RND) >>> GUARD;
      if (ev_e[i] > EV_MAX) begin
        ev_e[i] = EV_MAX;
      end else if (ev_e[i] < EV_MIN) begin
        ev_e[i] = EV_MIN;
      end
    end
    for (int i = 0; i < 3; i++) begin
      rank[i] = 2'd0;
      for (int j = 0; j < 3; j++) begin
        if (ev_r[j] > ev_r[i] || (ev_r[j] == ev_r[i] && j < i)) begin
          rank[i] = rank[i] + 2'd1;
        end
      end
    end
    sel = 2'd0;
    for (int i = 2; i >= 0; i--) begin
      if (rank[i] == emit_r) begin
        sel = 2'(i);
      end
    end
    for (int k = 0; k < 3; k++) begin
      vsel[k] = vec_r[k][sel];
      if (vsel[k] > ONE_V) begin
        vclp[k] = ONE_V;
      end else if (vsel[k] < -ONE_V) begin
        vclp[k] = -ONE_V;
      end else begin
        vclp[k] = vsel[k];
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= THR_W'(1);
      maxrot_r <= ROT_W'(50);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THRESHOLD: thr_r    <= cfg_wdata[THR_W-1:0];
        CFG_MAX_ROT:   maxrot_r <= cfg_wdata[ROT_W-1:0];
        default:       ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      k_r      <= PIV_01;
      it_r     <= '0;
      pc_r     <= '0;
      issued_r <= 1'b0;
      emit_r   <= '0;
      strobe_r <= 1'b0;
      last_r   <= 1'b0;
    end else begin
      strobe_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            diag_r[0] <= MAT_W'(in_entry_xx) <<< GUARD;
            diag_r[1] <= MAT_W'(in_entry_yy) <<< GUARD;
            diag_r[2] <= MAT_W'(in_entry_zz) <<< GUARD;
            off_r[0]  <= MAT_W'(in_entry_xy) <<< GUARD;
            off_r[1]  <= MAT_W'(in_entry_xz) <<< GUARD;
            off_r[2]  <= MAT_W'(in_entry_yz) <<< GUARD;
            for (int r = 0; r < 3; r++) begin
              for (int c = 0; c < 3; c++) begin
                vec_r[r][c] <= (r == c) ? ONE_V : '0;
              end
            end
            it_r    <= '0;
            state_r <= S_PIVOT;
          end
        end
        S_PIVOT: begin
          if (it_r >= maxrot_r || best < lim) begin
            state_r <= S_RANK;
          end else begin
            k_r     <= kbest;
            state_r <= S_LOAD;
            case (kbest)
              PIV_01: begin
                app_r <= diag_r[0]; aqq_r <= diag_r[1]; apq_r <= off_r[0];
                arp_r <= off_r[1];  arq_r <= off_r[2];
                for (int k = 0; k < 3; k++) begin
                  vp_r[k] <= vec_r[k][0];
                  vq_r[k] <= vec_r[k][1];
                end
              end
              PIV_02: begin
                app_r <= diag_r[0]; aqq_r <= diag_r[2]; apq_r <= off_r[1];
                arp_r <= off_r[0];  arq_r <= off_r[2];
                for (int k = 0; k < 3; k++) begin
                  vp_r[k] <= vec_r[k][0];
                  vq_r[k] <= vec_r[k][2];
                end
              end
              default: begin
                app_r <= diag_r[1]; aqq_r <= diag_r[2]; apq_r <= off_r[2];
                arp_r <= off_r[0];  arq_r <= off_r[1];
                for (int k = 0; k < 3; k++) begin
                  vp_r[k] <= vec_r[k][1];
                  vq_r[k] <= vec_r[k][2];
                end
              end
            endcase
          end
        end
        S_LOAD: begin
          state_r <= S_VEC;
        end
        S_VEC: begin
          if (c_done) begin
            state_r <= S_ROT;
          end
        end
        S_ROT: begin
          if (c_done) begin
            c_r      <= c_c;
            s_r      <= c_s;
            pc_r     <= '0;
            issued_r <= 1'b0;
            state_r  <= S_MUL;
          end
        end
        S_MUL: begin
          if (!issued_r) begin
            issued_r <= 1'b1;
          end else if (m_done) begin
            acc_r[mop.d] <= acc_nxt;
            issued_r     <= 1'b0;
            if (pc_r == 5'(NUM_OPS - 1)) begin
              state_r <= S_COMMIT;
            end else begin
              pc_r <= pc_r + 5'd1;
            end
          end
        end
        S_COMMIT: begin
          it_r    <= it_r + ROT_W'(1);
          state_r <= S_PIVOT;
          case (k_r)
            PIV_01: begin
              diag_r[0] <= npp; diag_r[1] <= nqq; off_r[0] <= '0;
              off_r[1]  <= nrp; off_r[2]  <= nrq;
              for (int k = 0; k < 3; k++) begin
                vec_r[k][0] <= nvp[k];
                vec_r[k][1] <= nvq[k];
              end
            end
            PIV_02: begin
              diag_r[0] <= npp; diag_r[2] <= nqq; off_r[1] <= '0;
              off_r[0]  <= nrp; off_r[2]  <= nrq;
              for (int k = 0; k < 3; k++) begin
                vec_r[k][0] <= nvp[k];
                vec_r[k][2] <= nvq[k];
              end
            end
            default: begin
              diag_r[1] <= npp; diag_r[2] <= nqq; off_r[2] <= '0;
              off_r[0]  <= nrp; off_r[1]  <= nrq;
              for (int k = 0; k < 3; k++) begin
                vec_r[k][1] <= nvp[k];
                vec_r[k][2] <= nvq[k];
              end
            end
          endcase
        end
        S_RANK: begin
          for (int i = 0; i < 3; i++) begin
            ev_r[i] <= ev_e[i][DATA_WIDTH-1:0];
          end
          emit_r  <= '0;
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          strobe_r <= 1'b1;
          eig_r    <= ev_r[sel];
          vx_r     <= vclp[0][OUT_W-1:0];
          vy_r     <= vclp[1][OUT_W-1:0];
          vz_r     <= vclp[2][OUT_W-1:0];
          rank_r   <= emit_r;
          last_r   <= (emit_r == 2'd2);
          if (emit_r == 2'd2) begin
            state_r <= S_IDLE;
          end else begin
            emit_r <= emit_r + 2'd1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy            = (state_r != S_IDLE);
  assign out_strobe      = strobe_r;
  assign out_eigen_value = eig_r;
  assign out_vector_x    = vx_r;
  assign out_vector_y    = vy_r;
  assign out_vector_z    = vz_r;
  assign out_rank_index  = rank_r;
  assign out_last        = last_r;

  `JES3_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy, "busy not raised")
  `JES3_ASSERT_NXT(a_words_run, clk, rst_n, out_strobe && !out_last, out_strobe, "word gap")
  `JES3_ASSERT_IMP(a_last_rank, clk, rst_n, out_strobe && out_last, out_rank_index == 2'd2, "last rank")
  `JES3_ASSERT_IMP(a_mul_idle, clk, rst_n, m_start, !m_done, "multiplier overlap")

endmodule

// File: sv/jes3_cordic.sv
// ----------------------------------------------------------------------------
// Jacobi 3x3 CORDIC unit
// Shared vectoring (atan2 with normalization) and rotation (sin/cos) engine.
// ----------------------------------------------------------------------------
module jes3_cordic (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start_vec,
  input  logic                               start_rot,
  input  logic signed [jes3_pkg::MAT_W-1:0]  vx_in,
  input  logic signed [jes3_pkg::MAT_W-1:0]  vy_in,
  input  logic signed [jes3_pkg::Z_W-1:0]    rz_in,
  output logic                               done,
  output logic signed [jes3_pkg::Z_W-1:0]    z_out,
  output logic signed [jes3_pkg::CS_W-1:0]   c_out,
  output logic signed [jes3_pkg::CS_W-1:0]   s_out
);
  import jes3_pkg::*;

  typedef enum logic [2:0] {
    C_IDLE = 3'b001,
    C_NORM = 3'b010,
    C_RUN  = 3'b100
  } cst_t;

  cst_t                    state_r;
  logic                    done_r;
  logic                    vec_r;
  logic [4:0]              i_r;
  logic signed [MAT_W-1:0] x_r, y_r;
  logic signed [Z_W-1:0]   z_r;

  logic [MAT_W-1:0]        ax, ay, m;
  logic signed [MAT_W-1:0] dx, dy;
  logic signed [Z_W-1:0]   t;
  logic                    pos;

  always_comb begin
    ax  = x_r[MAT_W-1] ? -x_r : x_r;
    ay  = y_r[MAT_W-1] ? -y_r : y_r;
    m   = (ax > ay) ? ax : ay;
    dx  = y_r >>> i_r;
    dy  = x_r >>> i_r;
    t   = {{(Z_W-32){1'b0}}, atan_q30(i_r)};
    pos = vec_r ? !y_r[MAT_W-1] : z_r[Z_W-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done_r  <= 1'b0;
      vec_r   <= 1'b0;
      i_r     <= '0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        C_IDLE: begin
          if (start_vec) begin
            vec_r <= 1'b1;
            if (vx_in == '0 && vy_in == '0) begin
              z_r    <= '0;
              done_r <= 1'b1;
            end else if (vx_in[MAT_W-1]) begin
              x_r     <= -vx_in;
              y_r     <= -vy_in;
              z_r     <= vy_in[MAT_W-1] ? -PI_Q30 : PI_Q30;
              state_r <= C_NORM;
            end else begin
              x_r     <= vx_in;
              y_r     <= vy_in;
              z_r     <= '0;
              state_r <= C_NORM;
            end
          end else if (start_rot) begin
            vec_r   <= 1'b0;
            x_r     <= GAIN_Q30;
            y_r     <= '0;
            z_r     <= rz_in;
            i_r     <= '0;
            state_r <= C_RUN;
          end
        end
        C_NORM: begin
          if (m < NORM_COARSE) begin
            x_r <= x_r <<< 8;
            y_r <= y_r <<< 8;
          end else if (m < NORM_LEVEL) begin
            x_r <= x_r <<< 1;
            y_r <= y_r <<< 1;
          end else begin
            i_r     <= '0;
            state_r <= C_RUN;
          end
        end
        C_RUN: begin
          if (pos) begin
            x_r <= x_r + dx;
            y_r <= y_r - dy;
            z_r <= z_r + t;
          end else begin
            x_r <= x_r - dx;
            y_r <= y_r + dy;
            z_r <= z_r - t;
          end
          if (i_r == 5'(CORDIC_STEPS - 1)) begin
            done_r  <= 1'b1;
            state_r <= C_IDLE;
          end else begin
            i_r <= i_r + 5'd1;
          end
        end
        default: state_r <= C_IDLE;
      endcase
    end
  end

  assign done  = done_r;
  assign z_out = z_r;
  assign c_out = x_r[CS_W-1:0];
  assign s_out = y_r[CS_W-1:0];

endmodule

// File: sv/jes3_mulq.sv
// ----------------------------------------------------------------------------
// Jacobi 3x3 fixed-point multiplier
// Rounded 64 x 33 bit Q2.30 product on one 33 x 33 multiplier in two passes.
// ----------------------------------------------------------------------------
module jes3_mulq (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [jes3_pkg::MAT_W-1:0]  a_in,
  input  logic signed [jes3_pkg::CS_W-1:0]   b_in,
  output logic                               done,
  output logic signed [jes3_pkg::MAT_W-1:0]  y_out
);
  import jes3_pkg::*;

  typedef enum logic [3:0] {
    M_IDLE = 4'b0001,
    M_LO   = 4'b0010,
    M_HI   = 4'b0100,
    M_SUM  = 4'b1000
  } mst_t;

  mst_t                       state_r;
  logic                       done_r;
  logic signed [MAT_W-1:0]    a_r, y_r;
  logic signed [CS_W-1:0]     b_r;
  logic signed [2*CS_W-1:0]   plo_r, phi_r, prod;
  logic signed [CS_W-1:0]     m_a;
  logic [MAT_W+CS_W+1:0]      sum;

  always_comb begin
    m_a  = (state_r == M_LO) ? $signed({1'b0, a_r[31:0]})
                             : $signed({a_r[MAT_W-1], a_r[MAT_W-1:32]});
    prod = m_a * b_r;
    sum  = {phi_r, 32'd0} + {{32{plo_r[2*CS_W-1]}}, plo_r}
           + (MAT_W+CS_W+2)'(536870912);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        M_IDLE: begin
          if (start) begin
            a_r     <= a_in;
            b_r     <= b_in;
            state_r <= M_LO;
          end
        end
        M_LO: begin
          plo_r   <= prod;
          state_r <= M_HI;
        end
        M_HI: begin
          phi_r   <= prod;
          state_r <= M_SUM;
        end
        M_SUM: begin
          y_r     <= sum[MAT_W+29:30];
          done_r  <= 1'b1;
          state_r <= M_IDLE;
        end
        default: state_r <= M_IDLE;
      endcase
    end
  end

  assign done  = done_r;
  assign y_out = y_r;

endmodule

// File: tb/jacobi_eigen_symmetric_3x3_test.sv
// ----------------------------------------------------------------------------
// Jacobi 3x3 eigen solver testbench
// Drives symmetric matrices through the command port under several register
// settings and idle patterns, and compares every eigenpair word with a local
// fixed-point Jacobi solver or, for a few directed rows, a typed-in answer.
// ----------------------------------------------------------------------------
module jacobi_eigen_symmetric_3x3_test;
  import jes3_pkg::*;

  localparam int DW = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam longint Q30 = 64'sd1073741824;
  localparam longint Q30_HALF = 64'sd536870912;
  localparam longint PI30 = 64'sd3373259426;
  localparam longint GAIN30 = 64'sd652032874;
  localparam longint NORM = 64'sd1 << 40;
  localparam int WATCHDOG_LIMIT = 200000;

  typedef struct {
    logic signed [DW-1:0] value;
    logic signed [31:0] vx, vy, vz;
    logic [1:0] rank;
    logic last;
  } eigen_pair_t;

  typedef struct {
    logic [30:0] thr;
    logic [5:0] rot;
    logic signed [DW-1:0] m[6];
    bit typed;
    logic signed [DW-1:0] ev[3];
    int col[3];
  } row_t;

  logic clk = 0, rst_n = 0, start = 0, busy, cfg_we = 0;
  logic signed [DW-1:0] in_entry_xx = 0, in_entry_xy = 0, in_entry_xz = 0;
  logic signed [DW-1:0] in_entry_yy = 0, in_entry_yz = 0, in_entry_zz = 0;
  logic [CFG_IDX_W-1:0] cfg_index = 0;
  logic [CFG_DATA_W-1:0] cfg_wdata = 0;
  logic out_strobe, out_last;
  logic signed [DW-1:0] out_eigen_value;
  logic signed [31:0] out_vector_x, out_vector_y, out_vector_z;
  logic [1:0] out_rank_index;

  jacobi_eigen_symmetric_3x3 #(.DATA_WIDTH(DW)) dut (.*);

  always #5 clk = ~clk;

  longint atan_steps[31] = '{843314857, 497837829, 263043837, 133525159, 67021687,
    33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1};

  eigen_pair_t pending_pairs[$];
  logic [30:0] stop_level = 1;
  logic [5:0] rotation_cap = 50;
  int errors = 0, idle_pct = 0, watchdog = 0;

  logic [30:0] thr_set[4] = '{1, 0, 4096, 31'h7fffffff};
  logic [5:0] rot_set[4] = '{50, 8, 63, 1};
  int idle_set[4] = '{0, 48, 25, 0};

  function automatic longint mul_q30(longint a, longint c);
    longint ah, al;
    ah = a >>> 30;
    al = a - ah * Q30;
    return ah * c + ((al * c + Q30_HALF) >>> 30);
  endfunction

  function automatic longint angle_of(longint x, longint y);
    longint z, m, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? PI30 : -PI30;
      x = -x;
      y = -y;
    end
    m = (x < 0 ? -x : x) > (y < 0 ? -y : y) ? (x < 0 ? -x : x) : (y < 0 ? -y : y);
    while (m < NORM) begin
      x = x * 2; y = y * 2; m = m * 2;
    end
    for (int i = 0; i < 31; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_steps[i];
      end else begin
        x -= dx; y += dy; z -= atan_steps[i];
      end
    end
    return z;
  endfunction

  task automatic cos_sin(input longint z, output longint c, output longint s);
    longint x, y, dx, dy;
    x = GAIN30;
    y = 0;
    for (int i = 0; i < 31; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_steps[i];
      end else begin
        x += dx; y -= dy; z += atan_steps[i];
      end
    end
    c = x;
    s = y;
  endtask

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  task automatic solve_matrix(input logic signed [DW-1:0] m[6]);
    int pp[3] = '{0, 0, 1};
    int qq[3] = '{1, 2, 2};
    longint a[3][3], v[3][3], ev[3], lim, best, c, s, cc, ss, cs, app, aqq, apq, arp, arq;
    longint vp, vq, e, x;
    int p, q, r, rank, n;
    eigen_pair_t slot[3];
    a[0][0] = longint'(m[0]); a[0][1] = longint'(m[1]); a[0][2] = longint'(m[2]);
    a[1][1] = longint'(m[3]); a[1][2] = longint'(m[4]); a[2][2] = longint'(m[5]);
    for (int i = 0; i < 3; i++)
      for (int j = i; j < 3; j++) begin
        a[i][j] = a[i][j] * 256;
        a[j][i] = a[i][j];
        v[i][j] = (i == j) ? Q30 : 0;
        v[j][i] = v[i][j];
      end
    lim = longint'(stop_level) * 256;
    for (int it = 0; it < rotation_cap; it++) begin
      p = 0; q = 1;
      best = mag(a[0][1]);
      for (int k = 1; k < 3; k++)
        if (mag(a[pp[k]][qq[k]]) > best) begin
          best = mag(a[pp[k]][qq[k]]);
          p = pp[k];
          q = qq[k];
        end
      if (best < lim) break;
      r = 3 - p - q;
      app = a[p][p]; aqq = a[q][q]; apq = a[p][q];
      cos_sin(angle_of(aqq - app, 2 * apq) >>> 1, c, s);
      cc = mul_q30(c, c); ss = mul_q30(s, s); cs = mul_q30(c, s);
      a[p][p] = mul_q30(app, cc) - 2 * mul_q30(apq, cs) + mul_q30(aqq, ss);
      a[q][q] = mul_q30(app, ss) + 2 * mul_q30(apq, cs) + mul_q30(aqq, cc);
      a[p][q] = 0; a[q][p] = 0;
      arp = a[r][p]; arq = a[r][q];
      a[r][p] = mul_q30(arp, c) - mul_q30(arq, s); a[p][r] = a[r][p];
      a[r][q] = mul_q30(arp, s) + mul_q30(arq, c); a[q][r] = a[r][q];
      for (int k = 0; k < 3; k++) begin
        vp = v[k][p]; vq = v[k][q];
        v[k][p] = mul_q30(vp, c) - mul_q30(vq, s);
        v[k][q] = mul_q30(vp, s) + mul_q30(vq, c);
      end
    end
    for (int i = 0; i < 3; i++) begin
      e = (a[i][i] + 128) >>> 8;
      if (e > 64'sd2147483647) e = 64'sd2147483647;
      if (e < -64'sd2147483648) e = -64'sd2147483648;
      ev[i] = e;
    end
    for (int i = 0; i < 3; i++) begin
      rank = 0;
      for (int j = 0; j < 3; j++)
        if (ev[j] > ev[i] || (ev[j] == ev[i] && j < i)) rank++;
      slot[rank].value = DW'(ev[i]);
      for (int k = 0; k < 3; k++) begin
        x = v[k][i];
        if (x > Q30) x = Q30;
        if (x < -Q30) x = -Q30;
        if (k == 0) slot[rank].vx = 32'(x);
        else if (k == 1) slot[rank].vy = 32'(x);
        else slot[rank].vz = 32'(x);
      end
      slot[rank].rank = 2'(rank);
      slot[rank].last = (rank == 2);
    end
    for (n = 0; n < 3; n++) pending_pairs = {pending_pairs, slot[n]};
  endtask

  always @(posedge clk) begin
    eigen_pair_t w;
    if (rst_n && out_strobe) begin
      if (pending_pairs.size() == 0) begin
        $display("%0t: unexpected word value=%0d rank=%0d", $time, out_eigen_value,
                 out_rank_index);
        errors++;
      end else begin
        w = pending_pairs.pop_front();
        if (out_eigen_value !== w.value || out_vector_x !== w.vx ||
            out_vector_y !== w.vy || out_vector_z !== w.vz ||
            out_rank_index !== w.rank || out_last !== w.last) begin
          $display("%0t: expected val=%0d v=(%0d,%0d,%0d) rank=%0d last=%0d", $time,
                   w.value, w.vx, w.vy, w.vz, w.rank, w.last);
          $display("%0t:   actual val=%0d v=(%0d,%0d,%0d) rank=%0d last=%0d", $time,
                   out_eigen_value, out_vector_x, out_vector_y, out_vector_z,
                   out_rank_index, out_last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) watchdog <= 0;
    else watchdog <= watchdog + 1;
    if (watchdog >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_pairs.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [30:0] data);
    @(negedge clk);
    start = 0;
    wait_idle();
    @(negedge clk);
    cfg_we = 1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 0;
    if (idx == CFG_THRESHOLD) stop_level = data;
    else if (idx == CFG_MAX_ROT) rotation_cap = data[5:0];
  endtask

  task automatic send_matrix(input logic signed [DW-1:0] m[6], input bit predict);
    @(negedge clk);
    if ($urandom_range(99) < idle_pct) begin
      start = 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    {in_entry_xx, in_entry_xy, in_entry_xz} = {m[0], m[1], m[2]};
    {in_entry_yy, in_entry_yz, in_entry_zz} = {m[3], m[4], m[5]};
    start = 1;
    do @(posedge clk); while (busy);
    if (predict) solve_matrix(m);
  endtask

  function automatic logic signed [DW-1:0] rand_entry(int bits);
    logic signed [DW-1:0] r;
    r = $urandom;
    if (bits >= 31) return r;
    return r >>> (31 - bits);
  endfunction

  localparam logic signed [DW-1:0] MAXV = 32'sh7fffffff;
  localparam logic signed [DW-1:0] MINV = 32'sh80000000;
  localparam logic signed [DW-1:0] ONE = 32'sh00010000;

  row_t plan[] = '{
    '{1, 50, '{0, 0, 0, 0, 0, 0}, 1, '{0, 0, 0}, '{0, 1, 2}},
    '{1, 0, '{5 * ONE, ONE, -ONE, -3 * ONE, 2 * ONE, 7 * ONE}, 1,
      '{7 * ONE, 5 * ONE, -3 * ONE}, '{2, 0, 1}},
    '{1, 0, '{MAXV, MINV, MAXV, MINV, 0, 0}, 1, '{MAXV, 0, MINV}, '{0, 2, 1}},
    '{1, 0, '{ONE, 0, 0, ONE, 0, ONE}, 1, '{ONE, ONE, ONE}, '{0, 1, 2}},
    '{1, 50, '{2 * ONE, ONE, 0, 2 * ONE, 0, 3 * ONE}, 0, '{0, 0, 0}, '{0, 0, 0}},
    '{1, 50, '{MAXV, MAXV, MAXV, MAXV, MAXV, MAXV}, 0, '{0, 0, 0}, '{0, 0, 0}},
    '{1, 50, '{MINV, MINV, MINV, MINV, MINV, MINV}, 0, '{0, 0, 0}, '{0, 0, 0}},
    '{1, 50, '{MAXV, MINV, MAXV, MINV, MAXV, MINV}, 0, '{0, 0, 0}, '{0, 0, 0}},
    '{1, 50, '{ONE, 0, 3 * ONE, 4 * ONE, 0, ONE}, 0, '{0, 0, 0}, '{0, 0, 0}},
    '{1, 50, '{0, 0, 0, 0, -5 * ONE, 0}, 0, '{0, 0, 0}, '{0, 0, 0}},
    '{0, 3, '{ONE, 0, 0, ONE, 0, ONE}, 0, '{0, 0, 0}, '{0, 0, 0}},
    '{0, 5, '{3 * ONE, ONE, 2, -ONE, 7, 5}, 0, '{0, 0, 0}, '{0, 0, 0}},
    '{31'h7fffffff, 63, '{ONE, 9 * ONE, ONE, 2, ONE, -ONE}, 0, '{0, 0, 0}, '{0, 0, 0}},
    '{65536, 63, '{-ONE, 9 * ONE, 7 * ONE, 2, 3 * ONE, -ONE}, 0, '{0, 0, 0}, '{0, 0, 0}},
    '{1, 1, '{4 * ONE, 2 * ONE, ONE, 3 * ONE, ONE, 2 * ONE}, 0, '{0, 0, 0}, '{0, 0, 0}},
    '{0, 63, '{4 * ONE, 2 * ONE, ONE, 3 * ONE, ONE, 2 * ONE}, 0, '{0, 0, 0}, '{0, 0, 0}}
  };

  initial begin
    logic signed [DW-1:0] m[6];
    eigen_pair_t w;
    int mode, bits;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    write_reg(CFG_UNUSED, 31'h5a5a5a5a);
    foreach (plan[i]) begin
      if (plan[i].thr != stop_level) write_reg(CFG_THRESHOLD, plan[i].thr);
      if (plan[i].rot != rotation_cap) write_reg(CFG_MAX_ROT, 31'(plan[i].rot));
      if (plan[i].typed) begin
        for (int k = 0; k < 3; k++) begin
          w.value = plan[i].ev[k];
          w.vx = 32'(plan[i].col[k] == 0 ? Q30 : 64'sd0);
          w.vy = 32'(plan[i].col[k] == 1 ? Q30 : 64'sd0);
          w.vz = 32'(plan[i].col[k] == 2 ? Q30 : 64'sd0);
          w.rank = 2'(k);
          w.last = (k == 2);
          pending_pairs = {pending_pairs, w};
        end
      end
      send_matrix(plan[i].m, !plan[i].typed);
    end
    for (int ph = 0; ph < 4; ph++) begin
      @(negedge clk);
      start = 0;
      write_reg(CFG_THRESHOLD, thr_set[ph]);
      write_reg(CFG_MAX_ROT, 31'(rot_set[ph]));
      idle_pct = idle_set[ph];
      for (int n = 0; n < 36; n++) begin
        mode = $urandom_range(9);
        bits = $urandom_range(4, 30);
        foreach (m[k]) m[k] = (mode < 2) ? $urandom : rand_entry(bits);
        if (mode == 9) begin
          m[1] = 0; m[2] = 0; m[4] = 0;
          m[3] = m[0];
        end
        if (n == 18) begin
          @(negedge clk);
          start = 0;
          wait_idle();
        end
        send_matrix(m, 1);
      end
    end
    @(negedge clk);
    start = 0;
    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

// File: files.f
+incdir+sv
sv/jes3_pkg.sv
sv/jes3_cordic.sv
sv/jes3_mulq.sv
sv/jacobi_eigen_symmetric_3x3.sv
tb/jacobi_eigen_symmetric_3x3_test.sv
